@@ rtl/core/scmb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scmb_pkg
// Shared types and constants for the serial command memory bridge.
// ----------------------------------------------------------------------------
package scmb_pkg;

    localparam int CHUNK_WORDS_DEFAULT = 128;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_AT = 8'h40;
    localparam logic [7:0] CH_A  = 8'h41;
    localparam logic [7:0] CH_B  = 8'h42;
    localparam logic [7:0] CH_C  = 8'h43;
    localparam logic [7:0] CH_D  = 8'h44;
    localparam logic [7:0] CH_X  = 8'h58;
    localparam logic [7:0] CH_M  = 8'h4D;

    localparam logic       OP_SERIAL = 1'b0;
    localparam logic       OP_RDATA  = 1'b1;

    localparam logic [1:0] KIND_TX    = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_BAD   = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE, PH_CMD, PH_MODE, PH_ADDR, PH_COUNT,
        PH_DIR, PH_LEN, PH_WDATA, PH_RWAIT
    } phase_t;

    typedef enum logic [2:0] {
        CM_NONE, CM_A, CM_B, CM_C, CM_D, CM_X, CM_M
    } cmd_t;

    // One batch of results caused by a single input. The results always come
    // in the order: returned word (low, high byte), write request, '@', read request.
    typedef struct packed {
        logic        has_data;
        logic        has_write;
        logic        has_at;
        logic        has_read;
        logic [15:0] data;
        logic [31:0] addr;
    } batch_t;

endpackage

@@ rtl/core/scmb_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scmb_front
// Frame parser: takes one item per cycle while the queue has room and queues the batch it causes.
// ----------------------------------------------------------------------------
module scmb_front import scmb_pkg::*; #(
    parameter int CHUNK_WORDS = CHUNK_WORDS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_fire,
    input  logic        in_op,
    input  logic [7:0]  in_byte,
    input  logic [15:0] in_rdata,
    output logic        push,
    output batch_t      push_batch
);

    localparam int CPW = $clog2(CHUNK_WORDS + 1);
    localparam logic [31:0] CHUNK32 = 32'(CHUNK_WORDS);

    phase_t      phase_reg, phase_next;
    cmd_t        cmd_reg, cmd_next;
    logic [1:0]  bidx_reg, bidx_next;
    logic [31:0] addr_reg, addr_next;
    logic [7:0]  wl_reg, wl_next;
    logic [CPW-1:0] cp_reg, cp_next;
    logic [7:0]  held_reg, held_next;
    logic        wdir_reg, wdir_next;

    batch_t      b;
    logic [7:0]  capped_byte;
    logic [7:0]  bt_count;
    logic        bt_dir;
    logic        bt_go;
    logic [7:0]  wl_dec;
    logic [CPW-1:0] cp_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cmd_reg   <= CM_NONE;
            bidx_reg  <= '0;
            addr_reg  <= '0;
            wl_reg    <= '0;
            cp_reg    <= '0;
            held_reg  <= '0;
            wdir_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            bidx_reg  <= bidx_next;
            addr_reg  <= addr_next;
            wl_reg    <= wl_next;
            cp_reg    <= cp_next;
            held_reg  <= held_next;
            wdir_reg  <= wdir_next;
        end
    end

    assign capped_byte = ({24'd0, in_byte} > CHUNK32) ? CHUNK32[7:0] : in_byte;
    assign wl_dec = wl_reg - 8'd1;
    assign cp_inc = cp_reg + CPW'(1);

    always_comb begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        bidx_next  = bidx_reg;
        addr_next  = addr_reg;
        wl_next    = wl_reg;
        cp_next    = cp_reg;
        held_next  = held_reg;
        wdir_next  = wdir_reg;
        b          = '0;
        bt_go      = 1'b0;
        bt_count   = '0;
        bt_dir     = 1'b0;

        if (in_fire) begin
            if (in_op == OP_RDATA) begin
                if (phase_reg == PH_RWAIT) begin
                    b.has_data = 1'b1;
                    b.data     = in_rdata;
                    wl_next    = wl_dec;
                    addr_next  = addr_reg + 32'd1;
                    cp_next    = cp_inc;
                    if (wl_dec != 8'd0) begin
                        if (cmd_reg == CM_M && 32'(cp_inc) >= CHUNK32) begin
                            b.has_at = 1'b1;
                            cp_next  = '0;
                        end
                        b.has_read = 1'b1;
                        b.addr     = addr_reg + 32'd1;
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
            end else begin
                case (phase_reg)
                    PH_IDLE: begin
                        if (in_byte == CH_AT) phase_next = PH_CMD;
                    end
                    PH_CMD: begin
                        bidx_next  = '0;
                        addr_next  = '0;
                        phase_next = PH_ADDR;
                        if (in_byte == CH_A)      cmd_next = CM_A;
                        else if (in_byte == CH_B) cmd_next = CM_B;
                        else if (in_byte == CH_C) cmd_next = CM_C;
                        else if (in_byte == CH_D) cmd_next = CM_D;
                        else if (in_byte == CH_X) cmd_next = CM_X;
                        else if (in_byte == CH_M) begin
                            cmd_next   = CM_M;
                            phase_next = PH_MODE;
                        end else begin
                            cmd_next   = CM_NONE;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_MODE: begin
                        if (in_byte[7:1] == 7'd0) begin
                            wdir_next  = in_byte[0];
                            phase_next = PH_ADDR;
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_ADDR: begin
                        addr_next = {addr_reg[23:0], in_byte};
                        bidx_next = bidx_reg + 2'd1;
                        if (bidx_reg == 2'd3) begin
                            bidx_next = '0;
                            case (cmd_reg)
                                CM_A: begin bt_go = 1'b1; bt_count = 8'd1; bt_dir = 1'b0; end
                                CM_B: begin bt_go = 1'b1; bt_count = 8'd1; bt_dir = 1'b1; end
                                CM_C: begin bt_go = 1'b1; bt_count = 8'd2; bt_dir = 1'b0; end
                                CM_D: begin bt_go = 1'b1; bt_count = 8'd2; bt_dir = 1'b1; end
                                CM_X: phase_next = PH_COUNT;
                                CM_M: phase_next = PH_LEN;
                                default: phase_next = PH_IDLE;
                            endcase
                        end
                    end
                    PH_COUNT: begin
                        wl_next    = capped_byte;
                        phase_next = PH_DIR;
                    end
                    PH_DIR: begin
                        bt_go    = 1'b1;
                        bt_count = wl_reg;
                        bt_dir   = (in_byte != 8'd0);
                    end
                    PH_LEN: begin
                        bt_go    = 1'b1;
                        bt_count = wdir_reg ? capped_byte : in_byte;
                        bt_dir   = wdir_reg;
                    end
                    PH_WDATA: begin
                        if (bidx_reg == 2'd0) begin
                            held_next = in_byte;
                            bidx_next = 2'd1;
                        end else begin
                            bidx_next   = '0;
                            b.has_write = 1'b1;
                            b.addr      = addr_reg;
                            b.data      = (cmd_reg == CM_M) ? {held_reg, in_byte}
                                                            : {in_byte, held_reg};
                            addr_next   = addr_reg + 32'd1;
                            wl_next     = wl_dec;
                            if (wl_dec == 8'd0) begin
                                b.has_at   = 1'b1;
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    default: ;
                endcase

                // Start of a transfer once all operands are in.
                if (bt_go) begin
                    wl_next   = bt_count;
                    wdir_next = bt_dir;
                    bidx_next = '0;
                    cp_next   = '0;
                    if (bt_dir) begin
                        if (bt_count == 8'd0) begin
                            b.has_at   = 1'b1;
                            phase_next = PH_IDLE;
                        end else begin
                            phase_next = PH_WDATA;
                        end
                    end else begin
                        b.has_at = 1'b1;
                        if (bt_count == 8'd0) begin
                            phase_next = PH_IDLE;
                        end else begin
                            b.has_read = 1'b1;
                            b.addr     = addr_next;
                            phase_next = PH_RWAIT;
                        end
                    end
                end
            end
        end
    end

    assign push       = b.has_data | b.has_write | b.has_at | b.has_read;
    assign push_batch = b;

endmodule

@@ rtl/core/scmb_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scmb_fifo
// Short batch queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module scmb_fifo import scmb_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  batch_t push_batch,
    input  logic   pop,
    output batch_t head,
    output logic   empty,
    output logic   full
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    batch_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wptr_reg, rptr_reg;
    logic [PW:0]     count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign head  = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + PW'(1);
            if (pop)  rptr_reg <= rptr_reg + PW'(1);
            count_reg <= count_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wptr_reg] <= push_batch;
    end

endmodule

@@ rtl/core/scmb_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scmb_back
// Result sequencer: unpacks each batch into results, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module scmb_back import scmb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  batch_t      head,
    input  logic        empty,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_tx_byte,
    output logic [31:0] m_mem_address,
    output logic [15:0] m_write_data,
    output logic        m_last
);

    // Slots: 0 low byte, 1 high byte, 2 write, 3 '@', 4 read.
    batch_t      cur_reg;
    logic [4:0]  mask_reg, mask_next;
    logic [4:0]  first;
    logic [4:0]  rest;
    logic        load;

    logic        valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  tx_reg;
    logic [31:0] addr_reg;
    logic [15:0] data_reg;
    logic        last_reg;

    assign first = mask_reg & (~mask_reg + 5'd1);
    assign rest  = mask_reg & ~first;
    assign load  = (mask_reg != '0) && (!valid_reg || m_ready);
    assign pop   = !empty && ((load ? rest : mask_reg) == '0);

    always_comb begin
        mask_next = load ? rest : mask_reg;
        if (pop) begin
            mask_next = {head.has_read, head.has_at, head.has_write,
                         head.has_data, head.has_data};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            mask_reg <= mask_next;
            if (load) valid_reg <= 1'b1;
            else if (m_ready) valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) cur_reg <= head;
        if (load) begin
            kind_reg <= KIND_TX;
            tx_reg   <= '0;
            addr_reg <= '0;
            data_reg <= '0;
            last_reg <= (rest == '0);
            if (first[0]) tx_reg <= cur_reg.data[7:0];
            if (first[1]) tx_reg <= cur_reg.data[15:8];
            if (first[3]) tx_reg <= CH_AT;
            if (first[2]) begin
                kind_reg <= KIND_WRITE;
                addr_reg <= cur_reg.addr;
                data_reg <= cur_reg.data;
            end
            if (first[4]) begin
                kind_reg <= KIND_READ;
                addr_reg <= cur_reg.addr;
            end
        end
    end

    assign m_valid       = valid_reg;
    assign m_kind        = kind_reg;
    assign m_tx_byte     = tx_reg;
    assign m_mem_address = addr_reg;
    assign m_write_data  = data_reg;
    assign m_last        = last_reg;

endmodule

@@ rtl/core/serial_command_memory_bridge_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_memory_bridge_top
// Serial command frames in, transmit bytes and word memory requests out.
// ----------------------------------------------------------------------------
// The bridge takes one input transfer per cycle, either a received serial
// byte or a word returned for the last read request, and answers with zero to
// four result transfers: transmit bytes, memory read requests or memory write
// requests, with m_last marking the final result of each input. A parser in
// front handles one input per cycle and places the results it causes, as one
// batch, into a four-entry queue; a sequencer behind it sends one result per
// cycle while the output is not stalled, through a registered output. So the
// sustained rate is set by the sequencer, not by the parser. The input side
// keeps accepting while results wait, until the queue is full. Reads are
// issued one at a time; the next read request follows the returned word.
// ----------------------------------------------------------------------------
module serial_command_memory_bridge_top import scmb_pkg::*; #(
    parameter int CHUNK_WORDS = CHUNK_WORDS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_rx_byte,
    input  logic [15:0] s_read_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_tx_byte,
    output logic [31:0] m_mem_address,
    output logic [15:0] m_write_data,
    output logic        m_last
);

    logic   push, pop, empty, full;
    batch_t push_batch, head;

    // The input side stalls only when the batch queue is full.
    assign s_ready = !full;

    scmb_front #(.CHUNK_WORDS(CHUNK_WORDS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (s_valid && s_ready),
        .in_op      (s_op),
        .in_byte    (s_rx_byte),
        .in_rdata   (s_read_data),
        .push       (push),
        .push_batch (push_batch)
    );

    scmb_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_batch (push_batch),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    scmb_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .empty         (empty),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_tx_byte     (m_tx_byte),
        .m_mem_address (m_mem_address),
        .m_write_data  (m_write_data),
        .m_last        (m_last)
    );

endmodule

@@ rtl/core/scmb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scmb_checker
// Port-level checks on the result channel of the bridge.
// ----------------------------------------------------------------------------
module scmb_checker import scmb_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_kind,
    input logic [7:0]  m_tx_byte,
    input logic [15:0] m_write_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_kind != KIND_BAD)
        else $error("undefined result kind");

    a_tx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_TX |-> m_tx_byte == 8'd0)
        else $error("transmit byte set on a memory request");

    a_rd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_WRITE |-> m_write_data == 16'd0)
        else $error("write data set on a non-write result");

endmodule

bind serial_command_memory_bridge_top scmb_checker u_scmb_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_kind       (m_kind),
    .m_tx_byte    (m_tx_byte),
    .m_write_data (m_write_data)
);
